// ===== rtl/core/ris_pkg.sv =====
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types, constants and helper functions of the rgb image sampler.
// ----------------------------------------------------------------------------
package ris_pkg;

  // image store geometry and coordinate format
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 20;
  localparam int ONE_FX     = 1 << FRAC_BITS;

  // field widths fixed by the interface
  localparam int FIELD_COL_W = 8;
  localparam int FIELD_ROW_W = 8;
  localparam int COLOR_W     = 24;
  localparam int CH_W        = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // derived widths
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WDIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W    = COORD_BITS - FRAC_BITS;
  localparam int W_W      = FRAC_BITS + 1;
  localparam int WT_W     = 2 * FRAC_BITS + 1;
  localparam int PROD_W   = CH_W + WT_W;
  localparam int ACC_W    = CH_W + 2;

  // input item kinds
  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  // kernel selection
  typedef enum logic {
    KM_NEAREST  = 1'b0,
    KM_BILINEAR = 1'b1
  } kernel_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_HOLD
  } state_t;

  // clamped corners and per-axis weights of one sample
  typedef struct packed {
    logic [1:0][COL_W-1:0] col;
    logic [1:0][ROW_W-1:0] row;
    logic [1:0][W_W-1:0]   wx;
    logic [1:0][W_W-1:0]   wy;
  } corner_t;

  // blend datapath controls
  typedef struct packed {
    logic clear;
    logic load_wt;
    logic mac;
  } blend_ctl_t;

  // zero reads as one, above the maximum saturates
  function automatic int limit_dim(int v, int maxd);
    if (v == 0) return 1;
    if (v > maxd) return maxd;
    return v;
  endfunction

  // clamp a corner index into [0, dim-1]
  function automatic int clamp_index(int i, int dim);
    if (i < 0) return 0;
    if (i > dim - 1) return dim - 1;
    return i;
  endfunction

  // store address of a pixel
  function automatic logic [ADDR_W-1:0] pix_addr(int row, int col);
    return ADDR_W'(row * MAX_WIDTH + col);
  endfunction

endpackage

// ===== rtl/core/rgb_image_sampler.sv =====
// ----------------------------------------------------------------------------
// rgb_image_sampler
// RGB888 image store with a bilinear or nearest-neighbour sampler.
// ----------------------------------------------------------------------------
// A write transaction stores one pixel. A sample transaction passes through the
// read, last and hold states before its result is loaded into the output
// register: the four corner pixels are read from the single-port image memory
// one per cycle, each read followed in the next cycle by a weighted add into
// the channel accumulators. The input stalls while a sample is being worked on;
// it is open again while a finished result still waits in the output register.
// Pixels never written since reset read back undefined.
// ----------------------------------------------------------------------------
module rgb_image_sampler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic [ris_pkg::FIELD_COL_W-1:0]       in_write_col,
  input  logic [ris_pkg::FIELD_ROW_W-1:0]       in_write_row,
  input  logic [ris_pkg::COLOR_W-1:0]           in_write_color,
  input  logic signed [ris_pkg::COORD_BITS-1:0] in_sample_x,
  input  logic signed [ris_pkg::COORD_BITS-1:0] in_sample_y,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ris_pkg::CH_W-1:0]              out_red,
  output logic [ris_pkg::CH_W-1:0]              out_green,
  output logic [ris_pkg::CH_W-1:0]              out_blue,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ris_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ris_pkg::CFG_DATA_W-1:0]        cfg_data
);

  ris_pkg::state_t                state_r, state_nxt;
  logic [1:0]                     cnt_r, cnt_nxt;
  logic [ris_pkg::WDIM_W-1:0]     width_r;
  logic [ris_pkg::HDIM_W-1:0]     height_r;
  logic                           mode_r;
  ris_pkg::corner_t               corner_r;
  ris_pkg::corner_t               corner_new;
  ris_pkg::blend_ctl_t            blend_ctl;
  logic                           in_take;
  logic                           take_write;
  logic                           take_sample;
  logic                           out_free;
  logic                           out_load;
  logic                           out_valid_r;
  logic [ris_pkg::CH_W-1:0]       out_red_r, out_green_r, out_blue_r;
  logic [ris_pkg::CH_W-1:0]       acc_red, acc_green, acc_blue;
  logic                           ram_we;
  logic [ris_pkg::ADDR_W-1:0]     ram_addr;
  logic [ris_pkg::COLOR_W-1:0]    ram_rdata;
  logic                           write_in_range;

  // handshakes
  assign cfg_ready   = 1'b1;
  assign in_stall    = (state_r != ris_pkg::ST_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign take_write  = in_take && (in_action == ris_pkg::ACT_WRITE);
  assign take_sample = in_take && (in_action == ris_pkg::ACT_SAMPLE);
  assign out_free    = !out_valid_r || !out_stall;

  // configuration registers, dimensions stored already limited
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ris_pkg::WDIM_W'(ris_pkg::MAX_WIDTH);
      height_r <= ris_pkg::HDIM_W'(ris_pkg::MAX_HEIGHT);
      mode_r   <= ris_pkg::KM_BILINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ris_pkg::CFG_WIDTH: begin
          width_r <= ris_pkg::WDIM_W'(ris_pkg::limit_dim(int'(cfg_data),
                                                         ris_pkg::MAX_WIDTH));
        end
        ris_pkg::CFG_HEIGHT: begin
          height_r <= ris_pkg::HDIM_W'(ris_pkg::limit_dim(int'(cfg_data),
                                                          ris_pkg::MAX_HEIGHT));
        end
        ris_pkg::CFG_MODE: begin
          mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // corner setup straight from the accepted coordinate
  ris_corner_setup u_setup (
    .sample_x (in_sample_x),
    .sample_y (in_sample_y),
    .width    (width_r),
    .height   (height_r),
    .mode     (mode_r),
    .corner   (corner_new)
  );

  always_ff @(posedge clk) begin
    if (take_sample) begin
      corner_r <= corner_new;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ris_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (take_sample) begin
          state_nxt = ris_pkg::ST_READ;
        end
      end
      ris_pkg::ST_READ: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ris_pkg::ST_LAST;
        end
      end
      ris_pkg::ST_LAST: begin
        state_nxt = ris_pkg::ST_HOLD;
      end
      ris_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = ris_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ris_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ris_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // memory and datapath controls
  assign write_in_range = (int'(in_write_col) < ris_pkg::MAX_WIDTH) &&
                          (int'(in_write_row) < ris_pkg::MAX_HEIGHT);

  always_comb begin
    ram_we          = 1'b0;
    ram_addr        = ris_pkg::pix_addr(int'(in_write_row), int'(in_write_col));
    blend_ctl.clear   = 1'b0;
    blend_ctl.load_wt = 1'b0;
    blend_ctl.mac     = 1'b0;
    out_load        = 1'b0;
    case (state_r)
      ris_pkg::ST_IDLE: begin
        ram_we          = take_write && write_in_range;
        blend_ctl.clear = take_sample;
      end
      ris_pkg::ST_READ: begin
        ram_addr = ris_pkg::pix_addr(int'(corner_r.row[cnt_r[0]]),
                                     int'(corner_r.col[cnt_r[1]]));
        blend_ctl.load_wt = 1'b1;
        blend_ctl.mac     = (cnt_r != 2'd0);
      end
      ris_pkg::ST_LAST: begin
        blend_ctl.mac = 1'b1;
      end
      ris_pkg::ST_HOLD: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  ris_pixel_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_write_color),
    .rdata (ram_rdata)
  );

  ris_blend u_blend (
    .clk   (clk),
    .ctl   (blend_ctl),
    .wx    (corner_r.wx[cnt_r[1]]),
    .wy    (corner_r.wy[cnt_r[0]]),
    .pixel (ram_rdata),
    .red   (acc_red),
    .green (acc_green),
    .blue  (acc_blue)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= acc_red;
      out_green_r <= acc_green;
      out_blue_r  <= acc_blue;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

`ifndef NO_ASSERTIONS
  // memory is written only between samples
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ris_pkg::ST_IDLE))
    else $error("pixel write during a sample");

  // fourth corner read is followed by the last accumulate
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ris_pkg::ST_READ && cnt_r == 2'd3) |=> (state_r == ris_pkg::ST_LAST))
    else $error("corner sequence did not end after four reads");

  // a result waits while the output register is occupied
  a_hold_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ris_pkg::ST_HOLD && !out_free) |=> (state_r == ris_pkg::ST_HOLD))
    else $error("result dropped while output busy");

  // a new result only appears from the hold state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ris_pkg::ST_HOLD))
    else $error("output loaded outside hold state");
`endif

endmodule

// ===== rtl/core/ris_pixel_ram.sv =====
// ----------------------------------------------------------------------------
// ris_pixel_ram
// Single-port image store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ris_pixel_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ris_pkg::ADDR_W-1:0] addr,
  input  logic [ris_pkg::COLOR_W-1:0] wdata,
  output logic [ris_pkg::COLOR_W-1:0] rdata
);

  logic [ris_pkg::COLOR_W-1:0] mem [ris_pkg::MEM_DEPTH];
  logic [ris_pkg::COLOR_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ris_corner_setup.sv =====
// ----------------------------------------------------------------------------
// ris_corner_setup
// Floors a fixed-point sample position, clamps the four corner indexes to the
// image in use and derives the per-axis kernel weights.
// ----------------------------------------------------------------------------
module ris_corner_setup (
  input  logic signed [ris_pkg::COORD_BITS-1:0] sample_x,
  input  logic signed [ris_pkg::COORD_BITS-1:0] sample_y,
  input  logic [ris_pkg::WDIM_W-1:0]            width,
  input  logic [ris_pkg::HDIM_W-1:0]            height,
  input  logic                                  mode,
  output ris_pkg::corner_t                      corner
);

  logic signed [ris_pkg::IDX_W-1:0] ix;
  logic signed [ris_pkg::IDX_W-1:0] iy;
  logic [ris_pkg::FRAC_BITS-1:0]    fx;
  logic [ris_pkg::FRAC_BITS-1:0]    fy;
  logic [ris_pkg::W_W-1:0]          one_w;

  // arithmetic shift of the integer part is a floor in two's complement
  assign ix    = sample_x[ris_pkg::COORD_BITS-1:ris_pkg::FRAC_BITS];
  assign iy    = sample_y[ris_pkg::COORD_BITS-1:ris_pkg::FRAC_BITS];
  assign fx    = sample_x[ris_pkg::FRAC_BITS-1:0];
  assign fy    = sample_y[ris_pkg::FRAC_BITS-1:0];
  assign one_w = ris_pkg::W_W'(ris_pkg::ONE_FX);

  // corner clamping and weights
  always_comb begin
    corner.col[0] = ris_pkg::COL_W'(ris_pkg::clamp_index(int'(ix), int'(width)));
    corner.col[1] = ris_pkg::COL_W'(ris_pkg::clamp_index(int'(ix) + 1, int'(width)));
    corner.row[0] = ris_pkg::ROW_W'(ris_pkg::clamp_index(int'(iy), int'(height)));
    corner.row[1] = ris_pkg::ROW_W'(ris_pkg::clamp_index(int'(iy) + 1, int'(height)));
    if (mode == ris_pkg::KM_BILINEAR) begin
      corner.wx[0] = one_w - {1'b0, fx};
      corner.wx[1] = {1'b0, fx};
      corner.wy[0] = one_w - {1'b0, fy};
      corner.wy[1] = {1'b0, fy};
    end else begin
      // nearest: fraction below one half picks the lower corner
      corner.wx[0] = fx[ris_pkg::FRAC_BITS-1] ? '0 : one_w;
      corner.wx[1] = fx[ris_pkg::FRAC_BITS-1] ? one_w : '0;
      corner.wy[0] = fy[ris_pkg::FRAC_BITS-1] ? '0 : one_w;
      corner.wy[1] = fy[ris_pkg::FRAC_BITS-1] ? one_w : '0;
    end
  end

endmodule

// ===== rtl/core/ris_blend.sv =====
// ----------------------------------------------------------------------------
// ris_blend
// Weight product register and per-channel accumulators; one corner pixel is
// folded in per cycle.
// ----------------------------------------------------------------------------
module ris_blend (
  input  logic                         clk,
  input  ris_pkg::blend_ctl_t          ctl,
  input  logic [ris_pkg::W_W-1:0]      wx,
  input  logic [ris_pkg::W_W-1:0]      wy,
  input  logic [ris_pkg::COLOR_W-1:0]  pixel,
  output logic [ris_pkg::CH_W-1:0]     red,
  output logic [ris_pkg::CH_W-1:0]     green,
  output logic [ris_pkg::CH_W-1:0]     blue
);

  logic [ris_pkg::WT_W-1:0]           wt_r;
  logic [2:0][ris_pkg::ACC_W-1:0]     acc_r;
  logic [2:0][ris_pkg::ACC_W-1:0]     acc_nxt;
  logic [2:0][ris_pkg::ACC_W-1:0]     term;
  logic [2:0][ris_pkg::CH_W-1:0]      ch;

  // corner weight, registered ahead of the channel multiply
  always_ff @(posedge clk) begin
    if (ctl.load_wt) begin
      wt_r <= ris_pkg::WT_W'(wx * wy);
    end
  end

  // channel split: index 2 red, 1 green, 0 blue
  assign ch = pixel;

  // truncated terms, one per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      term[c] = ris_pkg::ACC_W'((ris_pkg::PROD_W'(ch[c]) * ris_pkg::PROD_W'(wt_r))
                                >> (2 * ris_pkg::FRAC_BITS));
    end
  end

  // accumulate
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.mac) begin
      for (int c = 0; c < 3; c++) begin
        acc_nxt[c] = acc_r[c] + term[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign red   = acc_r[2][ris_pkg::CH_W-1:0];
  assign green = acc_r[1][ris_pkg::CH_W-1:0];
  assign blue  = acc_r[0][ris_pkg::CH_W-1:0];

endmodule

// ===== tb/tb_rgb_image_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_image_sampler
// Self-checking testbench for the rgb image sampler.
// ----------------------------------------------------------------------------
// A directed table runs first on the reset settings: corner pixels, integer,
// half and extreme sample positions, and an overwrite. Its plain cases carry
// a typed-in expected color. Random phases follow, each with its own image
// size and kernel, including zero and oversized dimensions and a write to the
// unused register index. Samples with no typed-in color are predicted from
// a local copy of the image and the registers. Before any sample, corner
// pixels that were never written get a write, so no undefined pixel is ever
// read. Both channels idle at random. One phase runs with no idling, one long
// output hold fills the block up, and one pause lets the block drain fully.
// ----------------------------------------------------------------------------
module tb_rgb_image_sampler;
  import ris_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int QUIET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 212;
  localparam int NUM_PHASES   = 8;
  localparam int CALM_PHASE   = 3;
  localparam int DRAIN_PHASE  = 5;
  localparam int NUM_DIR      = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // one input transaction
  typedef struct packed {
    action_t     act;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [23:0] color;
    logic [19:0] sx;
    logic [19:0] sy;
  } txn_t;

  // directed row: transaction plus an optional typed-in expected color
  typedef struct packed {
    txn_t        t;
    logic        typed;
    logic [23:0] want;
  } dir_row_t;

  // register setting of one random phase
  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    kernel_t    mode;
  } geom_t;

  // clamped corners and per-axis weights of one sample
  typedef struct packed {
    logic [1:0][7:0] col;
    logic [1:0][7:0] row;
    logic [1:0][8:0] wx;
    logic [1:0][8:0] wy;
  } taps_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{'{ACT_WRITE,  8'd0,   8'd0,   24'hFFFFFF, 20'h7FFFF, 20'h80000}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd1,   8'd0,   24'h000000, 20'h12345, 20'hABCDE}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd0,   8'd1,   24'h123456, 20'hFFFFF, 20'h00000}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd1,   8'd1,   24'hA5C3E7, 20'h00000, 20'hFFFFF}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd255, 8'd255, 24'hFEDCBA, 20'h55555, 20'hAAAAA}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd254, 8'd255, 24'h010203, 20'h0, 20'h0}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd255, 8'd254, 24'h808080, 20'h0, 20'h0}, 1'b0, 24'h0},
    '{'{ACT_WRITE,  8'd254, 8'd254, 24'h7F7F7F, 20'h0, 20'h0}, 1'b0, 24'h0},
    // integer positions pick one pixel
    '{'{ACT_SAMPLE, 8'd255, 8'd255, 24'hFFFFFF, 20'h00000, 20'h00000}, 1'b1, 24'hFFFFFF},
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h000000, 20'h00100, 20'h00000}, 1'b1, 24'h000000},
    '{'{ACT_SAMPLE, 8'hAA,  8'h55,  24'h5A5A5A, 20'h00000, 20'h00100}, 1'b1, 24'h123456},
    '{'{ACT_SAMPLE, 8'h55,  8'hAA,  24'hA5A5A5, 20'h00100, 20'h00100}, 1'b1, 24'hA5C3E7},
    // most negative position clamps to the origin, large ones to the far corner
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h80000, 20'h80000}, 1'b1, 24'hFFFFFF},
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h7FFFF, 20'h7FFFF}, 1'b0, 24'h0},
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h0FF00, 20'h0FF00}, 1'b1, 24'hFEDCBA},
    // half, just-below-half and just-above-half fractions
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h00080, 20'h00080}, 1'b0, 24'h0},
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h00080, 20'h00000}, 1'b0, 24'h0},
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h0007F, 20'h00181}, 1'b0, 24'h0},
    // small negative positions
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'hFFFFF, 20'hFFF80}, 1'b0, 24'h0},
    // overwrite, then read back
    '{'{ACT_WRITE,  8'd0,   8'd0,   24'h000000, 20'h0, 20'h0}, 1'b0, 24'h0},
    '{'{ACT_SAMPLE, 8'd0,   8'd0,   24'h0,      20'h00000, 20'h00000}, 1'b1, 24'h000000}
  };

  localparam geom_t PHASES [NUM_PHASES] = '{
    '{9'd256, 9'd256, KM_NEAREST},
    '{9'd1,   9'd1,   KM_BILINEAR},
    '{9'd0,   9'd0,   KM_NEAREST},
    '{9'd511, 9'd511, KM_BILINEAR},
    '{9'd300, 9'd2,   KM_NEAREST},
    '{9'd7,   9'd5,   KM_BILINEAR},
    '{9'd256, 9'd1,   KM_BILINEAR},
    '{9'd13,  9'd256, KM_NEAREST}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = 1'b0;
  logic [7:0]            in_write_col = '0;
  logic [7:0]            in_write_row = '0;
  logic [23:0]           in_write_color = '0;
  logic signed [19:0]    in_sample_x = '0;
  logic signed [19:0]    in_sample_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // local copy of the image and registers
  logic [23:0] image_model [0:65535];
  bit          pix_seen [0:65535];
  logic [8:0]  width_now = 9'd256;
  logic [8:0]  height_now = 9'd256;
  kernel_t     mode_now = KM_BILINEAR;

  logic [23:0] rgb_due [$];

  int cycle_count = 0;
  int mismatches = 0;
  int results_seen = 0;
  int n_writes = 0;
  int n_samples = 0;
  int n_fills = 0;
  int hold_asks = 0;
  int holds_served = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  rgb_image_sampler dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_write_col  (in_write_col),
    .in_write_row  (in_write_row),
    .in_write_color(in_write_color),
    .in_sample_x   (in_sample_x),
    .in_sample_y   (in_sample_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // zero reads as one, oversized saturates
  function automatic int dim_in_use(logic [8:0] d, int maxd);
    if (d == 0) return 1;
    return (d > maxd) ? maxd : int'(d);
  endfunction

  function automatic int clip_axis(int i, int dim);
    if (i < 0) return 0;
    return (i > dim - 1) ? dim - 1 : i;
  endfunction

  // lower and upper weight of one axis under the current kernel
  function automatic logic [1:0][8:0] pair_weights(int f);
    logic [1:0][8:0] w;
    if (mode_now == KM_BILINEAR) begin
      w[0] = 9'(ONE_FX - f);
      w[1] = 9'(f);
    end else if (f < ONE_FX / 2) begin
      w[0] = 9'(ONE_FX);
      w[1] = 9'd0;
    end else begin
      w[0] = 9'd0;
      w[1] = 9'(ONE_FX);
    end
    return w;
  endfunction

  // floor, clamp to the image in use, and weigh the four corners
  function automatic taps_t locate_taps(logic [19:0] sx, logic [19:0] sy);
    taps_t tp;
    int wd, ht, ix, iy, k;
    wd = dim_in_use(width_now, MAX_WIDTH);
    ht = dim_in_use(height_now, MAX_HEIGHT);
    ix = $signed(sx) >>> FRAC_BITS;
    iy = $signed(sy) >>> FRAC_BITS;
    for (k = 0; k < 2; k++) begin
      tp.col[k] = 8'(clip_axis(ix + k, wd));
      tp.row[k] = 8'(clip_axis(iy + k, ht));
    end
    tp.wx = pair_weights(int'(sx[FRAC_BITS-1:0]));
    tp.wy = pair_weights(int'(sy[FRAC_BITS-1:0]));
    return tp;
  endfunction

  // sum of four separately truncated weighted terms per channel
  function automatic logic [23:0] predict_rgb(logic [19:0] sx, logic [19:0] sy);
    taps_t tp;
    int acc [3];
    int a, b, c, wt;
    logic [23:0] px;
    tp = locate_taps(sx, sy);
    acc = '{0, 0, 0};
    for (a = 0; a < 2; a++) begin
      for (b = 0; b < 2; b++) begin
        px = image_model[{tp.row[b], tp.col[a]}];
        wt = int'(tp.wx[a]) * int'(tp.wy[b]);
        for (c = 0; c < 3; c++) begin
          acc[c] += (int'(px[(16 - 8 * c) +: 8]) * wt) >> (2 * FRAC_BITS);
        end
      end
    end
    return {acc[0][7:0], acc[1][7:0], acc[2][7:0]};
  endfunction

  function automatic logic [19:0] near_coord(int dim, bit on_edge);
    int whole, frac;
    whole = int'($urandom_range(dim + 3)) - 2;
    if (!on_edge) begin
      frac = $urandom_range(255);
    end else begin
      case ($urandom_range(4))
        0: frac = 0;
        1: frac = 1;
        2: frac = 127;
        3: frac = 128;
        default: frac = 255;
      endcase
    end
    return 20'(whole * ONE_FX + frac);
  endfunction

  function automatic logic [19:0] edge_coord();
    case ($urandom_range(3))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return 20'h00000;
      default: return 20'hFFFFF;
    endcase
  endfunction

  // drive one transaction, hold it until accepted, then update the model
  task automatic send_item(input txn_t t, input bit typed = 1'b0,
                           input logic [23:0] want = '0);
    int gap;
    logic [23:0] due;
    gap = (!calm && $urandom_range(99) < 23) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= t.act;
    in_write_col   <= t.col;
    in_write_row   <= t.row;
    in_write_color <= t.color;
    in_sample_x    <= t.sx;
    in_sample_y    <= t.sy;
    do @(posedge clk); while (in_stall);
    if (t.act == ACT_WRITE) begin
      image_model[{t.row, t.col}] = t.color;
      pix_seen[{t.row, t.col}] = 1'b1;
      n_writes++;
    end else begin
      due = typed ? want : predict_rgb(t.sx, t.sy);
      rgb_due = {rgb_due, due};
      n_samples++;
    end
  endtask

  // write any corner of the coming sample that holds no pixel yet
  task automatic cover_corners(input logic [19:0] sx, input logic [19:0] sy);
    taps_t tp;
    txn_t fill;
    int a, b;
    tp = locate_taps(sx, sy);
    for (a = 0; a < 2; a++) begin
      for (b = 0; b < 2; b++) begin
        if (!pix_seen[{tp.row[b], tp.col[a]}]) begin
          fill.act   = ACT_WRITE;
          fill.col   = tp.col[a];
          fill.row   = tp.row[b];
          fill.color = 24'($urandom);
          fill.sx    = 20'($urandom);
          fill.sy    = 20'($urandom);
          send_item(fill);
          n_fills++;
        end
      end
    end
  endtask

  task automatic random_item();
    txn_t t;
    int wd, ht, k;
    wd = dim_in_use(width_now, MAX_WIDTH);
    ht = dim_in_use(height_now, MAX_HEIGHT);
    t.col   = 8'($urandom);
    t.row   = 8'($urandom);
    t.color = 24'($urandom);
    t.sx    = 20'($urandom);
    t.sy    = 20'($urandom);
    if ($urandom_range(99) < 30) begin
      t.act = ACT_WRITE;
      // mostly inside the image in use
      if ($urandom_range(99) < 70) begin
        t.col = 8'($urandom_range(wd - 1));
        t.row = 8'($urandom_range(ht - 1));
      end
    end else begin
      t.act = ACT_SAMPLE;
      k = $urandom_range(99);
      if (k < 75) begin
        t.sx = near_coord(wd, k >= 60);
        t.sy = near_coord(ht, k >= 60);
      end else if (k >= 90) begin
        t.sx = edge_coord();
        t.sy = edge_coord();
      end
      cover_corners(t.sx, t.sy);
    end
    send_item(t);
  endtask

  // stop offering and wait until the block is drained and quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (rgb_due.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  width_now = val;
      CFG_HEIGHT: height_now = val;
      CFG_MODE:   mode_now = kernel_t'(val[0]);
      default: ;
    endcase
  endtask

  // output stall: random, or a long hold on request
  always @(posedge clk) begin
    if (hold_asks != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (rgb_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result r=%02h g=%02h b=%02h with nothing pending",
                   out_red, out_green, out_blue);
      end else begin
        want = rgb_due.pop_front();
        if (out_red !== want[23:16] || out_green !== want[15:8] ||
            out_blue !== want[7:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: exp r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                     cycle_count, want[23:16], want[15:8], want[7:0],
                     out_red, out_green, out_blue);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, rgb_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // main sequence
  initial begin
    int i, p, sent_base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table on the reset settings
    for (i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].t.act == ACT_SAMPLE)
        cover_corners(DIR_ROWS[i].t.sx, DIR_ROWS[i].t.sy);
      send_item(DIR_ROWS[i].t, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // random phases, each with its own image size and kernel
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_WIDTH, PHASES[p].width);
      write_reg(CFG_HEIGHT, PHASES[p].height);
      write_reg(CFG_MODE, {8'($urandom), PHASES[p].mode});
      if (p == 0)
        write_reg(CFG_SPARE, 9'($urandom));
      cfg_valid <= 1'b0;
      calm <= (p == CALM_PHASE);
      // corner fills count toward the phase budget
      i = 0;
      sent_base = n_writes + n_samples;
      while (n_writes + n_samples - sent_base < PHASE_ITEMS) begin
        if (p == 1 && i == 50)
          hold_asks <= hold_asks + 1;
        if (p == DRAIN_PHASE && i == 100) begin
          // let the block drain completely mid-phase
          in_valid <= 1'b0;
          do @(posedge clk); while (rgb_due.size() != 0);
        end
        random_item();
        i++;
      end
    end
    settle();

    mismatches += rgb_due.size();
    $display("covered %0d pixel writes (%0d corner fills) and %0d samples over %0d settings",
             n_writes, n_fills, n_samples, NUM_PHASES + 1);
    $display("%0d results checked in %0d cycles, %0d mismatches",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
